### hdl/cmt_pkg.sv
package cmt_pkg;

    localparam int NUM_WIDTH_DEF = 32;

endpackage

### hdl/carmichael_number_test_core.sv
// The number of divisions per candidate is one per trial divisor, up to
// sqrt(candidate), plus three per prime factor found and one final check.
// The worst case is a prime near 2**NUM_WIDTH.
// One candidate at a time; the shared bit-serial divider sets the pace.
// Reset (rst_n low, async) clears the sequencer and the output valid.
module carmichael_number_test_core
    import cmt_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [NUM_WIDTH-1:0] candidate,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 is_carmichael
);

    localparam int W     = NUM_WIDTH;
    localparam int CNT_W = $clog2(W + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TRIAL = 6'b000010,
        S_SQR   = 6'b000100,
        S_NM1   = 6'b001000,
        S_FINAL = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    typedef struct packed {
        logic         go;
        logic [W-1:0] dividend;
        logic [W-1:0] divisor;
    } div_cmd_t;

    state_t       state_reg, state_next;
    logic [W-1:0] n_reg, n_next;
    logic [W-1:0] k_reg, k_next;
    logic [W-1:0] u_reg, u_next;
    logic [W-1:0] qk_reg, qk_next;
    logic         res_reg, res_next;
    logic         out_valid_reg;
    logic         out_bit_reg;

    // shared restoring divider
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W:0]       rem_sh;
    logic [W:0]       diff;
    logic             div_done;
    div_cmd_t         cmd;

    logic [W-1:0] nm1;
    logic         out_free;

    assign nm1      = n_reg - W'(1);
    assign rem_sh   = {rem_reg, quo_reg[W-1]};
    assign diff     = rem_sh - {1'b0, dvs_reg};
    assign div_done = (cnt_reg == '0);
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign is_carmichael = out_bit_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        u_next     = u_reg;
        qk_next    = qk_reg;
        res_next   = res_reg;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next = candidate;
                    k_next = candidate;
                    u_next = W'(2);
                    if (candidate < W'(2))
                    begin
                        res_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.go       = 1'b1;
                        cmd.dividend = candidate;
                        cmd.divisor  = W'(2);
                        state_next   = S_TRIAL;
                    end
                end
            end
            S_TRIAL:
            begin
                if (div_done)
                begin
                    if (u_reg > quo_reg)
                    begin
                        // k is now the largest prime factor
                        if (k_reg == n_reg)
                        begin
                            res_next   = 1'b0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.go       = 1'b1;
                            cmd.dividend = nm1;
                            cmd.divisor  = k_reg - W'(1);
                            state_next   = S_FINAL;
                        end
                    end
                    else if (rem_reg == '0)
                    begin
                        qk_next      = quo_reg;
                        cmd.go       = 1'b1;
                        cmd.dividend = quo_reg;
                        cmd.divisor  = u_reg;
                        state_next   = S_SQR;
                    end
                    else
                    begin
                        u_next       = u_reg + W'(1);
                        cmd.go       = 1'b1;
                        cmd.dividend = k_reg;
                        cmd.divisor  = u_reg + W'(1);
                    end
                end
            end
            S_SQR:
            begin
                if (div_done)
                begin
                    if (rem_reg == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.go       = 1'b1;
                        cmd.dividend = nm1;
                        cmd.divisor  = u_reg - W'(1);
                        state_next   = S_NM1;
                    end
                end
            end
            S_NM1:
            begin
                if (div_done)
                begin
                    if (rem_reg != '0)
                    begin
                        res_next   = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        k_next       = qk_reg;
                        cmd.go       = 1'b1;
                        cmd.dividend = qk_reg;
                        cmd.divisor  = u_reg;
                        state_next   = S_TRIAL;
                    end
                end
            end
            S_FINAL:
            begin
                if (div_done)
                begin
                    res_next   = (rem_reg == '0);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.go)
            begin
                cnt_reg <= CNT_W'(W);
            end
            else if (!div_done)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        k_reg   <= k_next;
        u_reg   <= u_next;
        qk_reg  <= qk_next;
        res_reg <= res_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_bit_reg <= res_reg;
        end
        if (cmd.go)
        begin
            quo_reg <= cmd.dividend;
            rem_reg <= '0;
            dvs_reg <= cmd.divisor;
        end
        else if (!div_done)
        begin
            // one quotient bit per cycle
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

endmodule

### sim/carmichael_number_test_core_test.sv
module carmichael_number_test_core_test;
    import cmt_pkg::*;

    localparam int NW             = NUM_WIDTH_DEF;
    localparam int NUM_ROWS       = 23;
    localparam int RANDOM_ITEMS   = 80;
    localparam int HOLD_CYCLES    = 20000;
    localparam int WATCHDOG_LIMIT = 10000000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct {
        logic [NW-1:0] n;
        bit            known;
        bit            want;
    } directed_row_t;

    typedef struct {
        logic [NW-1:0] n;
        bit            verdict;
    } verdict_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [NW-1:0] candidate;
    logic          out_valid;
    logic          out_stall;
    logic          is_carmichael;

    verdict_t pending_verdicts [$];
    int       mismatches;
    int       send_idle_pct;
    int       recv_stall_pct;
    bit       hold_req;
    int       hold_left;
    int       quiet_cycles;

    // known answers only where they are obvious; the rest go through the predictor
    directed_row_t directed_rows [NUM_ROWS] = '{
        '{32'd0,          1'b1, 1'b0},
        '{32'd1,          1'b1, 1'b0},
        '{32'd2,          1'b1, 1'b0},
        '{32'd3,          1'b1, 1'b0},
        '{32'd4,          1'b1, 1'b0},
        '{32'd9,          1'b1, 1'b0},
        '{32'd49,         1'b1, 1'b0},
        '{32'd6,          1'b0, 1'b0},
        '{32'd15,         1'b0, 1'b0},
        '{32'd561,        1'b1, 1'b1},
        '{32'd1105,       1'b1, 1'b1},
        '{32'd1729,       1'b1, 1'b1},
        '{32'd8911,       1'b1, 1'b1},
        '{32'd65521,      1'b0, 1'b0},
        '{32'd1048573,    1'b0, 1'b0},
        '{32'd16777213,   1'b0, 1'b0},
        '{32'd1299963601, 1'b0, 1'b0},
        '{32'd2301745249, 1'b0, 1'b0},
        '{32'h8000_0000,  1'b1, 1'b0},
        '{32'hFFFF_FFFC,  1'b1, 1'b0},
        '{32'hFFFF_FFFF,  1'b0, 1'b0},
        '{32'h5555_5555,  1'b0, 1'b0},
        '{32'hAAAA_AAAA,  1'b0, 1'b0}
    };

    int unsigned odd_primes [46] = '{
        3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71, 73,
        79, 83, 89, 97, 101, 103, 107, 109, 113, 127, 131, 137, 139, 149, 151, 157,
        163, 167, 173, 179, 181, 191, 193, 197, 199, 211
    };

    int unsigned carmichael_list [16] = '{
        561, 1105, 1729, 2465, 2821, 6601, 8911, 10585, 15841, 29341, 41041, 46657,
        52633, 62745, 63973, 75361
    };

    carmichael_number_test_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .candidate    (candidate),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_carmichael(is_carmichael)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Korselt: composite, square-free, (p-1) | (n-1) for every prime factor p
    function automatic bit korselt_holds(input logic [NW-1:0] n);
        longint unsigned num;
        longint unsigned rem;
        longint unsigned nm1;
        longint unsigned d;
        num = n;
        if (num < 2)
            return 1'b0;
        nm1 = num - 1;
        rem = num;
        d   = 2;
        while (d <= rem / d)
        begin
            if (rem % d == 0)
            begin
                if ((rem / d) % d == 0)
                    return 1'b0;
                if (nm1 % (d - 1) != 0)
                    return 1'b0;
                rem = rem / d;
            end
            else
                d++;
        end
        return (rem != num) && (nm1 % (rem - 1) == 0);
    endfunction

    function automatic logic [NW-1:0] pick_candidate();
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int          kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2:
                return carmichael_list[$urandom_range(0, 15)];
            3, 4:
            begin
                // square-free composite from distinct odd primes, sometimes doubled
                a = $urandom_range(0, 45);
                b = (a + $urandom_range(1, 45)) % 46;
                c = odd_primes[a] * odd_primes[b];
                if ($urandom_range(0, 1))
                begin
                    a = (b + $urandom_range(1, 44)) % 46;
                    if (odd_primes[a] != c / odd_primes[b])
                        c = c * odd_primes[a];
                end
                if ($urandom_range(0, 3) == 0)
                    c = c * 2;
                return c;
            end
            5:
            begin
                a = odd_primes[$urandom_range(0, 20)];
                return a * a * $urandom_range(1, 300);
            end
            6, 7:
                return $urandom_range(0, 4095);
            8:
            begin
                // full-width values that fall out on a repeated small factor
                if ($urandom_range(0, 1))
                    return 9 * $urandom_range(0, 477218588);
                return $urandom & ~32'h3;
            end
            default:
            begin
                if ($urandom_range(0, 1))
                    return odd_primes[$urandom_range(0, 45)];
                return carmichael_list[$urandom_range(0, 15)] + $urandom_range(0, 4) - 2;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic send_candidate(input logic [NW-1:0] n, input bit known, input bit want);
        verdict_t v;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid  <= 1'b0;
            candidate <= $urandom;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= n;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        v.n       = n;
        v.verdict = known ? want : korselt_holds(n);
        pending_verdicts.insert(pending_verdicts.size(), v);
    endtask

    // receiver: random stall, plus a long hold counted here on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch($sformatf("unexpected beat, is_carmichael=%0b", is_carmichael));
            else
            begin
                v = pending_verdicts.pop_front();
                if (is_carmichael !== v.verdict)
                    report_mismatch($sformatf("candidate %0d: is_carmichael=%0b, want %0b",
                                              v.n, is_carmichael, v.verdict));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("** carmichael_number_test_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int phase;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        candidate      = '0;
        out_stall      = 1'b0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        hold_left      = 0;
        quiet_cycles   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_candidate(directed_rows[i].n, directed_rows[i].known, directed_rows[i].want);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            phase = i / (RANDOM_ITEMS / 4);
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            // back-pressure: results held off while the sender keeps offering beats
            if (i == RANDOM_ITEMS / 8)
                hold_req = 1'b1;
            send_candidate(pick_candidate(), 1'b0, 1'b0);
        end
        in_valid <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("** carmichael_number_test_core: PASSED **");
        else
            $display("** carmichael_number_test_core: FAILED **");
        $finish;
    end

endmodule

### filelist.f
hdl/cmt_pkg.sv
hdl/carmichael_number_test_core.sv
sim/carmichael_number_test_core_test.sv
